>>> rtl/core/cpbf_pkg.sv
package cpbf_pkg;

	// point store geometry
	localparam int MAX_POINTS = 1024;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = IDX_W + 1;

	// coordinates and derived widths
	localparam int COORD_W = 16;
	localparam int PT_W    = 2 * COORD_W;
	localparam int SQR_W   = 2 * COORD_W;
	localparam int SQ_W    = SQR_W + 1;

	// square root of (squared distance << 16), one result bit per step
	localparam int FRAC_SH   = 16;
	localparam int RAD_W     = ((SQ_W + FRAC_SH + 1) / 2) * 2;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int REM_W     = ROOT_W + 3;
	localparam int ITER_W    = $clog2(ROOT_W + 1);
	localparam int DIST_W    = 32;

	// cap of 10000000 in Q.8, reported when fewer than two points arrive
	localparam logic [DIST_W-1:0] DIST_CAP_Q8 = 32'd2560000000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_FETCH_WAIT,
		ST_SCAN,
		ST_DRAIN,
		ST_ROOT
	} state_t;

	// pair issued into the distance pipeline
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
	} pair_req_t;

	// finished squared distance with its pair tags
	typedef struct packed {
		logic             valid;
		logic [SQ_W-1:0]  sq;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
	} pair_res_t;

endpackage

>>> rtl/core/closest_pair_brute_force.sv
// Closest pair of points, exhaustive search. Points are loaded one request per
// cycle (start high while busy is low) and kept in a 1024-entry store; points
// past the 1024th are dropped. The request with last_point set is stored too and
// closes the set. With n >= 2 points busy then rises and every pair i<j is
// walked through a three-stage distance pipeline fed by the store's read port,
// one pair per cycle while a row is scanned, pausing between rows to fetch the
// next pivot. Once the pipeline has drained, the bit-serial square root runs
// its 25 steps and then done rises. With fewer than two points the result
// follows in the cycle after the request and busy does not rise. The result is
// flagged by done, high for a single cycle; it cannot be held off, so the
// receiver must take it then. Ties keep the first pair in scan order
// (i ascending, then j ascending).
module closest_pair_brute_force (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [cpbf_pkg::COORD_W-1:0] x_coord,
	input  logic signed [cpbf_pkg::COORD_W-1:0] y_coord,
	input  logic                               last_point,
	output logic                               done,
	output logic [cpbf_pkg::SQ_W-1:0]          min_sq_distance,
	output logic [cpbf_pkg::DIST_W-1:0]        distance_q8,
	output logic [cpbf_pkg::IDX_W-1:0]         first_index,
	output logic [cpbf_pkg::IDX_W-1:0]         second_index,
	output logic                               too_few_points
);
	import cpbf_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, n_q, n_next;
	logic [IDX_W-1:0] i_q, j_q, last_idx, pen_idx, rd_addr;
	logic [PT_W-1:0]  pivot_q, rd_data, wr_data;
	logic [SQ_W-1:0]  best_q;
	logic [IDX_W-1:0] bi_q, bj_q;
	logic             accept, room, sqrt_start, sqrt_done, dist_active;
	logic [ROOT_W-1:0] root;
	pair_req_t        req;
	pair_res_t        res;
	logic             done_q, too_few_q;
	logic [SQ_W-1:0]  min_sq_q;
	logic [DIST_W-1:0] dist_q;
	logic [IDX_W-1:0] first_q, second_q;

	assign accept   = start && (state_q == ST_IDLE);
	assign room     = count_q < CNT_W'(MAX_POINTS);
	assign n_next   = count_q + CNT_W'(room);
	assign last_idx = IDX_W'(n_q - CNT_W'(1));
	assign pen_idx  = IDX_W'(n_q - CNT_W'(2));

	// offset binary keeps the difference logic unsigned
	assign wr_data = {x_coord[COORD_W-1] ^ 1'b1, x_coord[COORD_W-2:0],
	                  y_coord[COORD_W-1] ^ 1'b1, y_coord[COORD_W-2:0]};

	cpbf_store u_store (
		.clk     (clk),
		.wr_en   (accept && room),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cpbf_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pivot  (pivot_q),
		.cand   (rd_data),
		.res    (res),
		.active (dist_active)
	);

	cpbf_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (best_q),
		.done   (sqrt_done),
		.root   (root)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state, store read address, pair issue
	always_comb begin
		state_d    = state_q;
		rd_addr    = j_q;
		req.valid  = 1'b0;
		req.i      = i_q;
		req.j      = j_q;
		sqrt_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && last_point && (n_next >= CNT_W'(2))) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				rd_addr = i_q;
				state_d = ST_FETCH_WAIT;
			end
			ST_FETCH_WAIT: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				req.valid = 1'b1;
				if (j_q == last_idx) begin
					state_d = (i_q == pen_idx) ? ST_DRAIN : ST_FETCH;
				end
			end
			ST_DRAIN: begin
				if (!dist_active) begin
					sqrt_start = 1'b1;
					state_d    = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (sqrt_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// point count and set size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			n_q     <= '0;
		end else if (accept) begin
			if (last_point) begin
				count_q <= '0;
				n_q     <= n_next;
			end else begin
				count_q <= n_next;
			end
		end
	end

	// pair walk indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					i_q <= '0;
				end
				ST_FETCH_WAIT: begin
					j_q <= i_q + 1'b1;
				end
				ST_SCAN: begin
					if (j_q == last_idx) begin
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// row pivot, loaded once the store read lands
	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH_WAIT) begin
			pivot_q <= rd_data;
		end
	end

	// running minimum; strict less-than keeps the first pair of a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '1;
			bi_q   <= '0;
			bj_q   <= '0;
		end else if (accept) begin
			best_q <= '1;
		end else if (res.valid && (res.sq < best_q)) begin
			best_q <= res.sq;
			bi_q   <= res.i;
			bj_q   <= res.j;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && last_point && (n_next < CNT_W'(2)))
			          || ((state_q == ST_ROOT) && sqrt_done);
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (accept && last_point && (n_next < CNT_W'(2))) begin
			min_sq_q  <= '0;
			dist_q    <= DIST_CAP_Q8;
			first_q   <= '0;
			second_q  <= '0;
			too_few_q <= 1'b1;
		end else if ((state_q == ST_ROOT) && sqrt_done) begin
			min_sq_q  <= best_q;
			dist_q    <= DIST_W'(root);
			first_q   <= bi_q;
			second_q  <= bj_q;
			too_few_q <= 1'b0;
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign min_sq_distance = min_sq_q;
	assign distance_q8     = dist_q;
	assign first_index     = first_q;
	assign second_index    = second_q;
	assign too_few_points  = too_few_q;

	// a result never appears while a search is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	// a found pair is always ordered
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !too_few_points) |-> (first_index < second_index))
		else $error("closest pair indices out of order");

	// a search starts only from a closing request
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && last_point))
		else $error("search started without a closing request");

	// the square root is only started once the pipeline is empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_start |-> !dist_active)
		else $error("square root started with pairs in flight");

endmodule

>>> rtl/core/cpbf_store.sv
module cpbf_store (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [cpbf_pkg::IDX_W-1:0] wr_addr,
	input  logic [cpbf_pkg::PT_W-1:0]  wr_data,
	input  logic [cpbf_pkg::IDX_W-1:0] rd_addr,
	output logic [cpbf_pkg::PT_W-1:0]  rd_data
);
	import cpbf_pkg::*;

	logic [PT_W-1:0] mem [MAX_POINTS];
	logic [PT_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/cpbf_dist.sv
module cpbf_dist (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cpbf_pkg::pair_req_t       req,
	input  logic [cpbf_pkg::PT_W-1:0] pivot,
	input  logic [cpbf_pkg::PT_W-1:0] cand,
	output cpbf_pkg::pair_res_t       res,
	output logic                      active
);
	import cpbf_pkg::*;

	logic                v_s1, v_s2, v_s3;
	logic [IDX_W-1:0]    i_s1, j_s1, i_s2, j_s2, i_s3, j_s3;
	logic [COORD_W-1:0]  dx_s2, dy_s2;
	logic [SQR_W-1:0]    sx_s3, sy_s3;
	logic [COORD_W-1:0]  px, py, cx, cy;

	// points are held in offset binary: x in the upper half, y in the lower
	assign px = pivot[PT_W-1:COORD_W];
	assign py = pivot[COORD_W-1:0];
	assign cx = cand[PT_W-1:COORD_W];
	assign cy = cand[COORD_W-1:0];

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// s1 tags line up with the store's registered read
	always_ff @(posedge clk) begin
		i_s1 <= req.i;
		j_s1 <= req.j;
	end

	// s2: absolute coordinate differences
	always_ff @(posedge clk) begin
		i_s2  <= i_s1;
		j_s2  <= j_s1;
		dx_s2 <= (px >= cx) ? (px - cx) : (cx - px);
		dy_s2 <= (py >= cy) ? (py - cy) : (cy - py);
	end

	// s3: squares
	always_ff @(posedge clk) begin
		i_s3  <= i_s2;
		j_s3  <= j_s2;
		sx_s3 <= SQR_W'(dx_s2) * SQR_W'(dx_s2);
		sy_s3 <= SQR_W'(dy_s2) * SQR_W'(dy_s2);
	end

	// final sum, compared against the best in the caller
	always_comb begin
		res.valid = v_s3;
		res.sq    = {1'b0, sx_s3} + {1'b0, sy_s3};
		res.i     = i_s3;
		res.j     = j_s3;
	end

	assign active = v_s1 | v_s2 | v_s3;

endmodule

>>> rtl/core/cpbf_sqrt.sv
module cpbf_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cpbf_pkg::SQ_W-1:0]   value,
	output logic                        done,
	output logic [cpbf_pkg::ROOT_W-1:0] root
);
	import cpbf_pkg::*;

	logic [ITER_W-1:0] iter_q;
	logic              done_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_sh, trial;
	logic              take;

	// one result bit per step: bring down two radicand bits, try 4r+1
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial  = REM_W'({root_q, 2'b01});
		take   = rem_sh >= trial;
	end

	// step counter and completion strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				iter_q <= ITER_W'(ROOT_W);
			end else if (iter_q != '0) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == ITER_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_W'({value, {FRAC_SH{1'b0}}});
			rem_q  <= '0;
			root_q <= '0;
		end else if (iter_q != '0) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
